// File: rtl/core/huffman_code_table_encoder_defines.svh
// assertion macros for the huffman code table encoder
`ifndef HUFFMAN_CODE_TABLE_ENCODER_DEFINES_SVH
`define HUFFMAN_CODE_TABLE_ENCODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HCTE_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HCTE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: rtl/core/hcte_pkg.sv
// shared types and constants of the huffman code table encoder
package hcte_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN     = 32;

  localparam int CMD_W    = 2;
  localparam int SYM_IN_W = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int BITS_W   = 4;
  localparam int STAT_W   = 2;
  localparam int KIND_W   = 2;

  // packer window: up to seven pending bits plus one full code
  localparam int WORK_W = CODE_W + BYTE_W;
  localparam int CNT_W  = $clog2(WORK_W);
  localparam int BSH_W  = $clog2(BYTE_W) + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // longest code that may be loaded
  localparam logic [LEN_W-1:0] LEN_LIMIT =
    (MAX_CODE_LEN < CODE_W) ? LEN_W'(MAX_CODE_LEN) : LEN_W'(CODE_W);

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PARTIAL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REJECT  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ENC    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [SYM_IN_W-1:0] symbol;
    logic [CODE_W-1:0]   code_value;
    logic [LEN_W-1:0]    code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [BITS_W-1:0] bits_in_byte;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } q_entry_t;

endpackage

// File: rtl/core/hcte_ram.sv
// generic single-write, registered-read ram
module hcte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// File: rtl/core/hcte_front.sv
// front end: accepts items, owns the code table, classifies work for the packer
module hcte_front import hcte_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  input  logic [QLVL_W-1:0] q_level,
  output logic              q_push,
  output q_entry_t          q_entry
);

  localparam int SYM_W  = $clog2(SYMBOL_COUNT);
  localparam int LIM_W  = SYM_IN_W + 1;
  localparam int QSUM_W = QLVL_W + 1;
  localparam int ENT_W  = LEN_W + CODE_W;
  localparam logic [LIM_W-1:0]  SYM_LIMIT = LIM_W'(SYMBOL_COUNT);
  localparam logic [QSUM_W-1:0] Q_LIMIT   = QSUM_W'(QUEUE_DEPTH);

  logic                    accept;
  logic                    sym_in_range;
  logic                    len_bad;
  logic                    is_load;
  logic                    is_enc;
  logic                    is_flush;
  logic                    load_ok;
  logic                    enc_rd;
  logic [SYM_W-1:0]        sym_idx;
  logic [QSUM_W-1:0]       q_sum;
  logic [ENT_W-1:0]        rd_data;
  logic [SYMBOL_COUNT-1:0] len_valid_r;
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  logic [KIND_W-1:0]       s1_kind_r;
  logic [KIND_W-1:0]       s1_kind_nxt;
  logic                    s1_lvalid_r;

  // an item held in s1 may still push, so count it as already queued
  assign q_sum    = {1'b0, q_level} + {{QLVL_W{1'b0}}, s1_valid_r};
  assign in_stall = q_sum >= Q_LIMIT;
  assign accept   = in_valid & ~in_stall;

  assign sym_idx      = in_item.symbol[SYM_W-1:0];
  assign sym_in_range = {1'b0, in_item.symbol} < SYM_LIMIT;
  assign len_bad      = in_item.code_length > LEN_LIMIT;

  always_comb begin
    is_load  = 1'b0;
    is_enc   = 1'b0;
    is_flush = 1'b0;
    case (in_item.command)
      CMD_LOAD:   is_load  = 1'b1;
      CMD_ENCODE: is_enc   = 1'b1;
      CMD_FLUSH:  is_flush = 1'b1;
      default:    ;
    endcase
  end

  assign load_ok = accept & is_load & sym_in_range & ~len_bad;
  assign enc_rd  = accept & is_enc & sym_in_range;

  always_comb begin
    s1_valid_nxt = 1'b0;
    s1_kind_nxt  = KIND_ENC;
    if (accept & is_load & ~(sym_in_range & ~len_bad)) begin
      s1_valid_nxt = 1'b1;
      s1_kind_nxt  = KIND_REJECT;
    end else if (enc_rd) begin
      s1_valid_nxt = 1'b1;
      s1_kind_nxt  = KIND_ENC;
    end else if (accept & is_flush) begin
      s1_valid_nxt = 1'b1;
      s1_kind_nxt  = KIND_FLUSH;
    end
  end

  hcte_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_ok),
    .wr_addr (sym_idx),
    .wr_data ({in_item.code_length, in_item.code_value}),
    .rd_en   (enc_rd),
    .rd_addr (sym_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_valid_r <= '0;
      s1_valid_r  <= 1'b0;
      s1_kind_r   <= KIND_ENC;
      s1_lvalid_r <= 1'b0;
    end else begin
      if (load_ok) begin
        len_valid_r[sym_idx] <= 1'b1;
      end
      s1_valid_r  <= s1_valid_nxt;
      s1_kind_r   <= s1_kind_nxt;
      s1_lvalid_r <= len_valid_r[sym_idx];
    end
  end

  // never-loaded entries read as length zero
  always_comb begin
    q_entry.kind = s1_kind_r;
    q_entry.code = rd_data[CODE_W-1:0];
    q_entry.len  = (s1_kind_r == KIND_ENC && s1_lvalid_r) ?
                   rd_data[ENT_W-1:CODE_W] : '0;
  end

  // unused symbols produce nothing downstream
  assign q_push = s1_valid_r & ((s1_kind_r != KIND_ENC) | (q_entry.len != '0));

endmodule

// File: rtl/core/hcte_queue.sv
// small flop-based queue between front and packer
module hcte_queue import hcte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  q_entry_t          push_entry,
  input  logic              pop,
  output logic              head_valid,
  output q_entry_t          head,
  output logic [QLVL_W-1:0] level
);

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QLVL_W-1:0] level_r;
  logic [QLVL_W-1:0] level_nxt;

  assign head_valid = level_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign level      = level_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (!push && pop) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

// File: rtl/core/hcte_back.sv
// back end: msb-first bit packer with output register
module hcte_back import hcte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  q_entry_t  head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam logic [CNT_W-1:0]  CNT_BYTE   = CNT_W'(BYTE_W);
  localparam logic [LEN_W-1:0]  LEN_CODE   = LEN_W'(CODE_W);
  localparam logic [BSH_W-1:0]  BSH_BYTE   = BSH_W'(BYTE_W);
  localparam logic [BITS_W-1:0] BITS_FULL  = BITS_W'(BYTE_W);

  // work_r holds unsent bits left aligned, all lower bits zero
  logic [WORK_W-1:0] work_r;
  logic [WORK_W-1:0] work_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_r;
  out_item_t         out_nxt;

  logic              can_load;
  logic              emit_byte;
  logic [WORK_W-1:0] base_work;
  logic [CNT_W-1:0]  base_cnt;
  logic [CNT_W-1:0]  rem_cnt;
  logic              head_enc;
  logic              pop_enc;
  logic              pop_other;
  logic [CODE_W-1:0] code_left;
  logic [WORK_W-1:0] code_ins;
  logic [BSH_W-1:0]  ins_shamt;

  assign can_load  = ~out_valid_r | ~out_stall;
  assign emit_byte = (cnt_r >= CNT_BYTE) & can_load;
  assign rem_cnt   = cnt_r - CNT_BYTE;
  assign base_work = emit_byte ? (work_r << BYTE_W) : work_r;
  assign base_cnt  = emit_byte ? rem_cnt : cnt_r;

  assign head_enc  = head_valid & (head.kind == KIND_ENC);
  // an encode may join in the cycle the last full byte leaves
  assign pop_enc   = head_enc & (base_cnt < CNT_BYTE);
  assign pop_other = head_valid & ~head_enc & (cnt_r < CNT_BYTE) & can_load;
  assign pop       = pop_enc | pop_other;

  // drop bits above the length, then place the code after the pending bits
  assign code_left = head.code << (LEN_CODE - head.len);
  assign ins_shamt = BSH_BYTE - {1'b0, base_cnt[BSH_W-2:0]};
  assign code_ins  = {{BYTE_W{1'b0}}, code_left} << ins_shamt;

  always_comb begin
    work_nxt      = base_work;
    cnt_nxt       = base_cnt;
    out_valid_nxt = can_load ? 1'b0 : out_valid_r;
    out_nxt       = out_r;
    if (emit_byte) begin
      out_valid_nxt        = 1'b1;
      out_nxt.data_byte    = work_r[WORK_W-1 -: BYTE_W];
      out_nxt.bits_in_byte = BITS_FULL;
      out_nxt.status       = STAT_FULL;
      out_nxt.last         = rem_cnt < CNT_BYTE;
    end
    if (pop_enc) begin
      work_nxt = base_work | code_ins;
      cnt_nxt  = base_cnt + CNT_W'(head.len);
    end else if (pop_other) begin
      case (head.kind)
        KIND_FLUSH: begin
          work_nxt = '0;
          cnt_nxt  = '0;
          if (cnt_r != '0) begin
            out_valid_nxt        = 1'b1;
            out_nxt.data_byte    = work_r[WORK_W-1 -: BYTE_W];
            out_nxt.bits_in_byte = {1'b0, cnt_r[BSH_W-2:0]};
            out_nxt.status       = STAT_PARTIAL;
            out_nxt.last         = 1'b1;
          end
        end
        default: begin
          out_valid_nxt        = 1'b1;
          out_nxt.data_byte    = '0;
          out_nxt.bits_in_byte = '0;
          out_nxt.status       = STAT_REJECT;
          out_nxt.last         = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      work_r      <= work_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: rtl/core/huffman_code_table_encoder.sv
// huffman code table encoder top: code table, command queue and msb-first bit packer
// in channel: in_valid/in_stall/in_item carry load, encode and flush commands.
// out channel: out_valid/out_stall/out_item carry packed bytes, flushed partial
// bytes and load rejects; last marks the final result of each command.
// an item is taken one per cycle while the four-entry queue has room; a table
// read is registered in the front stage s1, so in_stall rises once queue plus that
// stage hold four commands.
// a reject or flush passes s1, the queue and the output register before out_valid; the
// first byte of an encode also passes the packer work register. while out_stall is low
// the packer sends one byte per cycle and short codes run at one symbol per cycle.
// reset: pending bits cleared, every table length reads zero at once (one
// valid flop per entry), no clearing pass; code words are undefined until loaded.
// a stalled result stays in the output register while up to four more commands
// queue behind it.
`include "huffman_code_table_encoder_defines.svh"

module huffman_code_table_encoder import hcte_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam logic [QLVL_W-1:0] Q_FULL = QLVL_W'(QUEUE_DEPTH);

  logic              q_push;
  q_entry_t          q_entry;
  logic              q_pop;
  logic              q_valid;
  q_entry_t          q_head;
  logic [QLVL_W-1:0] q_level;

  hcte_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  hcte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head),
    .level      (q_level)
  );

  hcte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  `HCTE_ASSERT_IMPLY(a_no_push_full, clk, rst_n, q_push, q_level != Q_FULL, "push into full queue")
  `HCTE_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, q_pop, q_valid, "pop from empty queue")
  `HCTE_ASSERT_IMPLY(a_short_is_last, clk, rst_n, out_valid && out_item.status != STAT_FULL, out_item.last, "partial or reject result not last")

endmodule
